// ----- design/xdrt_pkg.sv -----
// Shared constants and status codes for the XOR-distance routing table.
// No dependencies.
`default_nettype none
package xdrt_pkg;
  localparam int ID_BITS_DEF      = 64;
  localparam int BUCKET_SLOTS_DEF = 8;
  localparam int MAX_RESULTS_DEF  = 64;
  localparam int ST_W    = 3;
  localparam int TIME_W  = 32;
  localparam int LIM_W   = 7;
  localparam logic [ST_W-1:0] ST_SELF    = 3'd0;
  localparam logic [ST_W-1:0] ST_REFRESH = 3'd1;
  localparam logic [ST_W-1:0] ST_APPEND  = 3'd2;
  localparam logic [ST_W-1:0] ST_CACHED  = 3'd3;
  localparam logic [ST_W-1:0] ST_EVICT   = 3'd4;
  localparam logic [ST_W-1:0] ST_CONTACT = 3'd5;
  localparam logic [ST_W-1:0] ST_NONE    = 3'd6;
endpackage
`default_nettype wire

// ----- design/xdrt_mem.sv -----
// Simple dual-port synchronous memory with registered read.
// No dependencies.
`default_nettype none
module xdrt_mem #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/xor_distance_routing_table.sv -----
// XOR-distance routing table: buckets by highest differing bit, with caches.
// Update: read slots, decide, write bucket and cache back, then hand over the result;
//   a self contact goes straight to the result.
// Query: one selection pass over all ID_BITS*2**SW slot addresses per result; one item
//   at a time, and a waiting result holds the input off.
// Reset clears own_id, then a clearing pass over the ID_BITS buckets zeroes the fill counts
//   with both ready outputs low; the slot memories need no sweep.
// Depends on xdrt_pkg and xdrt_mem.
`default_nettype none
module xor_distance_routing_table #(
  parameter int ID_BITS      = xdrt_pkg::ID_BITS_DEF,
  parameter int BUCKET_SLOTS = xdrt_pkg::BUCKET_SLOTS_DEF,
  parameter int MAX_RESULTS  = xdrt_pkg::MAX_RESULTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [63:0] node_id,
  input  wire logic [31:0] seen_time,
  input  wire logic        head_alive,
  input  wire logic [6:0]  result_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [63:0]      contact_id,
  output logic [31:0]      contact_time,
  output logic             last
);
  import xdrt_pkg::*;

  localparam int SW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int BW    = $clog2(ID_BITS);
  localparam int TOTAL = ID_BITS * (2 ** SW);
  localparam int AW    = $clog2(TOTAL);
  localparam int FW    = $clog2(BUCKET_SLOTS + 1);
  localparam int EW    = ID_BITS + TIME_W;
  localparam int RW    = $clog2(MAX_RESULTS + 1);
  localparam int CW    = AW + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDB   = 4'd1;  // read bucket and cache slots into a local copy
  localparam logic [3:0] S_CLR   = 4'd2;  // clear the fill counts after reset
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_WRB   = 4'd4;  // write bucket back
  localparam logic [3:0] S_WRS   = 4'd5;  // write cache back
  localparam logic [3:0] S_QSCAN = 4'd6;  // selection pass
  localparam logic [3:0] S_QEMIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [ID_BITS-1:0] own_id, rq_id;
  logic [TIME_W-1:0] rq_time;
  logic rq_alive;
  logic [RW-1:0] rq_lim, sent;
  logic [CW-1:0] nstored;
  logic [BW-1:0] bk;
  logic [CW-1:0] cnt;
  logic [ID_BITS-1:0] bid [BUCKET_SLOTS];
  logic [TIME_W-1:0]  btm [BUCKET_SLOTS];
  logic [ID_BITS-1:0] sid [BUCKET_SLOTS];
  logic [TIME_W-1:0]  stm [BUCKET_SLOTS];
  logic [FW-1:0] nbf, nsf;

  // Fill counts: {bucket fill, cache fill} per bucket, one registered read port
  logic [2*FW-1:0] fills [ID_BITS];
  logic [2*FW-1:0] fill_q, f_wd;
  logic f_we;
  logic [BW-1:0] f_wa, f_ra;
  logic [FW-1:0] cur_bf, cur_sf, dec_bf, dec_sf;
  assign cur_bf = fill_q[2*FW-1 -: FW];
  assign cur_sf = fill_q[FW-1:0];

  // Previous emitted key (distance, slot address) and current best
  logic [ID_BITS-1:0] pd, bd;
  logic [AW-1:0] pa, ba;
  logic have_prev, have_best;
  logic [EW-1:0] best_e;

  // Memories
  logic b_we, s_we;
  logic [AW-1:0] b_wa, s_wa, b_ra, s_ra;
  logic [EW-1:0] b_wd, s_wd, b_rd, s_rd;
  xdrt_mem #(.WIDTH(EW), .DEPTH(TOTAL)) u_bmem (.clk(clk), .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  xdrt_mem #(.WIDTH(EW), .DEPTH(TOTAL)) u_smem (.clk(clk), .we(s_we), .waddr(s_wa),
    .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  // Give a pending configuration write the idle cycle before any input item
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Bucket of an id: highest set bit of its distance
  function automatic logic [BW-1:0] hb(input logic [ID_BITS-1:0] d);
    logic [BW-1:0] r;
    r = '0;
    for (int k = 0; k < ID_BITS; k++) if (d[k]) r = BW'(k);
    return r;
  endfunction

  logic [ID_BITS-1:0] dist_in;
  assign dist_in = node_id[ID_BITS-1:0] ^ own_id;

  // Scan pipeline: the address issued last cycle yields data this cycle
  logic [AW-1:0] scan_a, prv_a;
  logic scan_ok;
  logic [SW-1:0] slot_of;
  logic [ID_BITS-1:0] cd;
  logic later, better;
  assign scan_a  = cnt[AW-1:0];
  assign slot_of = prv_a[SW-1:0];
  assign cd      = b_rd[EW-1 -: ID_BITS] ^ rq_id;
  always_comb begin
    scan_ok = FW'(slot_of) < cur_bf;
    later   = !have_prev || (cd > pd) || (cd == pd && prv_a > pa);
    better  = !have_best || (cd < bd) || (cd == bd && prv_a < ba);
  end
  logic scan_live;
  logic is_last;
  assign is_last = (int'(sent) + 1 == int'(rq_lim)) || (int'(sent) + 1 == int'(nstored));

  // Local bucket-copy search
  logic hit;
  logic [SW-1:0] hit_i;
  logic shit;
  logic [SW-1:0] shit_i;
  always_comb begin
    hit = 1'b0; hit_i = '0; shit = 1'b0; shit_i = '0;
    for (int k = BUCKET_SLOTS - 1; k >= 0; k--) begin
      if (FW'(k) < cur_bf && bid[k] == rq_id) begin hit = 1'b1; hit_i = SW'(k); end
      if (FW'(k) < cur_sf && sid[k] == rq_id) begin shit = 1'b1; shit_i = SW'(k); end
    end
  end

  // New fill counts: grow the bucket on append, the cache on a fresh cache entry
  always_comb begin
    dec_bf = cur_bf; dec_sf = cur_sf;
    if (!hit && cur_bf < FW'(BUCKET_SLOTS)) dec_bf = cur_bf + 1'b1;
    else if (!hit && rq_alive && !shit && cur_sf != FW'(BUCKET_SLOTS))
      dec_sf = cur_sf + 1'b1;
  end

  logic [AW-1:0] base_a;
  assign base_a = AW'({bk, {SW{1'b0}}}) ;

  always_comb begin
    b_we = 1'b0; s_we = 1'b0;
    b_wa = base_a | AW'(cnt[SW-1:0]); s_wa = b_wa;
    b_wd = {bid[cnt[SW-1:0]], btm[cnt[SW-1:0]]};
    s_wd = {sid[cnt[SW-1:0]], stm[cnt[SW-1:0]]};
    b_ra = base_a | AW'(cnt[SW-1:0]); s_ra = b_ra;
    if (state == S_WRB) b_we = FW'(cnt[SW-1:0]) < nbf;
    if (state == S_WRS) s_we = FW'(cnt[SW-1:0]) < nsf;
    if (state == S_QSCAN) b_ra = scan_a;
  end

  always_comb begin
    f_we = 1'b0; f_wa = bk; f_wd = {dec_bf, dec_sf};
    f_ra = (state == S_QSCAN) ? scan_a[AW-1 -: BW] : bk;
    if (state == S_DEC) f_we = 1'b1;
    if (state == S_CLR) begin
      f_we = 1'b1; f_wa = cnt[BW-1:0]; f_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) fills[f_wa] <= f_wd;
    fill_q <= fills[f_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; own_id <= '0; out_valid <= 1'b0; cnt <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (cnt == CW'(ID_BITS - 1)) begin cnt <= '0; state <= S_IDLE; end
          else cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          if (cfg_valid) own_id <= cfg_data[ID_BITS-1:0];
          if (in_valid && in_ready) begin
            rq_id <= node_id[ID_BITS-1:0]; rq_time <= seen_time; rq_alive <= head_alive;
            rq_lim <= (result_limit > 7'(MAX_RESULTS)) ? RW'(MAX_RESULTS) : RW'(result_limit);
            bk <= hb(dist_in); cnt <= '0; sent <= '0; nstored <= '0;
            have_prev <= 1'b0; have_best <= 1'b0; scan_live <= 1'b0;
            contact_id <= '0; contact_time <= '0; last <= 1'b1;
            if (op) state <= S_QSCAN;
            else if (dist_in == '0) begin
              status <= ST_SELF; out_valid <= 1'b1; state <= S_OUT;
            end else state <= S_RDB;
          end
        end
        S_RDB: begin  // capture slot cnt-1 while issuing slot cnt
          if (cnt != '0) {bid[cnt[SW-1:0]-1'b1], btm[cnt[SW-1:0]-1'b1]} <= b_rd;
          if (cnt != '0) {sid[cnt[SW-1:0]-1'b1], stm[cnt[SW-1:0]-1'b1]} <= s_rd;
          if (cnt == CW'(BUCKET_SLOTS)) begin cnt <= '0; state <= S_DEC; end
          else cnt <= cnt + 1'b1;
        end
        S_DEC: begin
          nbf <= dec_bf; nsf <= dec_sf;
          if (hit) begin
            for (int k = 0; k < BUCKET_SLOTS - 1; k++)
              if (SW'(k) >= hit_i && FW'(k + 2) <= cur_bf) begin
                bid[k] <= bid[k + 1]; btm[k] <= btm[k + 1];
              end
            bid[SW'(cur_bf - 1'b1)] <= rq_id; btm[SW'(cur_bf - 1'b1)] <= rq_time;
            status <= ST_REFRESH;
          end else if (cur_bf < FW'(BUCKET_SLOTS)) begin
            bid[SW'(cur_bf)] <= rq_id; btm[SW'(cur_bf)] <= rq_time;
            status <= ST_APPEND;
          end else begin
            for (int k = 0; k < BUCKET_SLOTS - 1; k++) begin
              bid[k] <= bid[k + 1]; btm[k] <= btm[k + 1];
            end
            if (rq_alive) begin
              bid[BUCKET_SLOTS-1] <= bid[0]; btm[BUCKET_SLOTS-1] <= btm[0];
              // drop duplicate, or the oldest if full, then append
              for (int k = 0; k < BUCKET_SLOTS - 1; k++)
                if ((shit && SW'(k) >= shit_i && FW'(k + 2) <= cur_sf) ||
                    (!shit && cur_sf == FW'(BUCKET_SLOTS))) begin
                  sid[k] <= sid[k + 1]; stm[k] <= stm[k + 1];
                end
              if (shit || cur_sf == FW'(BUCKET_SLOTS)) begin
                sid[SW'(cur_sf - 1'b1)] <= rq_id; stm[SW'(cur_sf - 1'b1)] <= rq_time;
              end else begin
                sid[SW'(cur_sf)] <= rq_id; stm[SW'(cur_sf)] <= rq_time;
              end
              status <= ST_CACHED;
            end else begin
              bid[BUCKET_SLOTS-1] <= rq_id; btm[BUCKET_SLOTS-1] <= rq_time;
              status <= ST_EVICT;
            end
          end
          state <= S_WRB;
        end
        S_WRB: begin
          if (cnt == CW'(BUCKET_SLOTS - 1)) begin cnt <= '0; state <= S_WRS; end
          else cnt <= cnt + 1'b1;
        end
        S_WRS: begin
          if (cnt == CW'(BUCKET_SLOTS - 1)) begin out_valid <= 1'b1; state <= S_OUT; end
          else cnt <= cnt + 1'b1;
        end
        S_QSCAN: begin
          prv_a <= scan_a; scan_live <= (cnt != CW'(TOTAL));
          // count stored contacts on the first pass so the final result is known
          if (scan_live && scan_ok && !have_prev) nstored <= nstored + 1'b1;
          if (scan_live && scan_ok && later && better) begin
            have_best <= 1'b1; bd <= cd; ba <= prv_a; best_e <= b_rd;
          end
          if (cnt == CW'(TOTAL)) state <= S_QEMIT;
          else cnt <= cnt + 1'b1;
        end
        S_QEMIT: begin
          cnt <= '0; scan_live <= 1'b0;
          if (sent == rq_lim || !have_best) begin
            if (sent == '0) begin
              status <= ST_NONE; last <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
            end else state <= S_IDLE;
          end else begin
            status <= ST_CONTACT; contact_id <= 64'(best_e[EW-1 -: ID_BITS]);
            contact_time <= best_e[TIME_W-1:0]; last <= is_last;
            pd <= bd; pa <= ba; have_prev <= 1'b1; have_best <= 1'b0;
            sent <= sent + 1'b1; out_valid <= 1'b1; state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= last ? S_IDLE : S_QSCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold a waiting result and its payload until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(contact_id) &&
      $stable(contact_time) && $stable(last));
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid));
  a_state_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(state));
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NONE);
endmodule
`default_nettype wire
